### rtl/gravity_accumulate_euler_body_macros.svh
// assertion macros for the gravity accumulator block
`ifndef GRAVITY_ACCUMULATE_EULER_BODY_MACROS_SVH
`define GRAVITY_ACCUMULATE_EULER_BODY_MACROS_SVH
`ifndef SYNTHESIS
`define GAE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define GAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GAE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GAE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/gae_pkg.sv
// shared types, constants and helpers of the gravity accumulator
package gae_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int UNIT_FRAC    = 30;
  localparam int DT_FRAC      = 16;
  localparam int DIV_NUM_BITS = 80;
  localparam int DIV_DEN_BITS = 64;
  localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS);
  localparam int SQ_IN_BITS   = 64;
  localparam int SQ_OUT_BITS  = SQ_IN_BITS / 2;
  localparam int SQ_CNT_BITS  = $clog2(SQ_OUT_BITS);
  localparam int MUL_BITS     = 33;

  localparam logic [31:0] RADIUS_RESET = 32'd458752;
  localparam logic [31:0] GRAV_RESET   = 32'd65536;
  localparam logic        REQ_TICK     = 1'b1;

  typedef logic [2:0] cfg_addr_t;
  localparam cfg_addr_t CFG_START_X  = 3'd0;
  localparam cfg_addr_t CFG_START_Y  = 3'd1;
  localparam cfg_addr_t CFG_START_VX = 3'd2;
  localparam cfg_addr_t CFG_START_VY = 3'd3;
  localparam cfg_addr_t CFG_RADIUS   = 3'd4;
  localparam cfg_addr_t CFG_GRAV     = 3'd5;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic [31:0]        other_mass;
    logic [31:0]        other_radius;
    logic [15:0]        dt_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] acc_x_out;
    logic signed [31:0] acc_y_out;
    logic               overlaps;
    logic               coincident;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_I_AX, ST_I_AY, ST_I_RS, ST_I_OVL, ST_I_X, ST_I_Y, ST_I_GM,
    ST_I_SQRT, ST_I_DIVK, ST_I_WAITK, ST_I_DIVX, ST_I_WAITX, ST_I_MULX,
    ST_I_ACCX, ST_I_DIVY, ST_I_WAITY, ST_I_MULY, ST_I_ACCY,
    ST_T_AX, ST_T_AY, ST_T_VX, ST_T_VY, ST_T_PY, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_AX, MUL_AY, MUL_RS, MUL_X, MUL_Y, MUL_GM, MUL_KU,
    MUL_ACCX, MUL_ACCY, MUL_VELX, MUL_VELY
  } mul_sel_t;

  typedef enum logic [1:0] {DIV_K, DIV_X, DIV_Y} div_sel_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    logic     d2_load;
    logic     d2_add;
    logic     ovl_load;
    logic     r2_load;
    logic     r2_add;
    logic     gm_load;
    logic     sqrt_start;
    logic     div_start;
    div_sel_t div_sel;
    logic     k_load;
    logic     u_load;
    logic     accx_upd;
    logic     accy_upd;
    logic     velx_upd;
    logic     vely_upd;
    logic     posx_upd;
    logic     posy_upd;
    logic     acc_clr;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_tick;
    logic coin;
    logic div_busy;
    logic sqrt_busy;
  } ctrl_stat_t;

  localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

  // base plus a signed magnitude, clamped to the word range
  function automatic logic signed [31:0] sat_add(logic signed [31:0] base,
                                                 logic [31:0] mag, logic neg);
    logic signed [33:0] addend;
    logic signed [33:0] sum;
    addend = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum    = $signed({{2{base[31]}}, base}) + addend;
    if (sum > SUM_MAX) begin
      return SUM_MAX[31:0];
    end else if (sum < SUM_MIN) begin
      return SUM_MIN[31:0];
    end
    return sum[31:0];
  endfunction

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

### rtl/gravity_accumulate_euler_body.sv
// top level of the one-body gravity accumulator with semi-implicit euler update
`include "gravity_accumulate_euler_body_macros.svh"
// Holds one body's position, velocity and accumulated acceleration in signed
// Q16.16 and works on one item at a time. An interaction item (req_type 0)
// adds G*m*d/|d|^3 toward the other body to the acceleration and reports
// overlap; a tick item (req_type 1) updates velocity, then position, by dt
// and clears the acceleration. Every item yields exactly one result item.
// An interaction at coincident positions skips the force terms; any other
// interaction runs three 80-step restoring divisions (force magnitude, then
// x and y unit parts), and the 32-step square root runs beside the first
// division. One 33x33 multiplier is shared by all products. The result sits
// in an output register, so the next item is taken while the previous
// result waits. Register writes on cfg_* land at once; writing a start
// position or velocity also loads the live state. There is no clearing
// pass after reset.
module gravity_accumulate_euler_body (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gae_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gae_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  gae_pkg::cfg_addr_t cfg_addr,
  input  logic [31:0]        cfg_wdata
);
  import gae_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencer: owns the handshakes and steps the datapath
  gae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // body state, arithmetic units and result register
  gae_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  // an accepted item keeps the block busy on the next cycle
  `GAE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // equal positions always count as touching
  `GAE_ASSERT_IMPL(a_coin_overlaps, clk, rst_n, out_valid && out_data.coincident,
                   out_data.overlaps)
  // a division is never launched while one is still running
  `GAE_ASSERT_IMPL(a_div_free, clk, rst_n, cmd.div_start, !stat.div_busy)
endmodule

### rtl/gae_div.sv
// iterative restoring divider, one quotient bit per cycle
module gae_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [gae_pkg::DIV_NUM_BITS-1:0]   num,
  input  logic [gae_pkg::DIV_DEN_BITS-1:0]   den,
  output logic                               busy,
  output logic [gae_pkg::DIV_NUM_BITS-1:0]   quo
);
  import gae_pkg::*;

  logic [DIV_DEN_BITS-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_BITS-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_BITS-1:0] den_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    busy_r;
  logic [DIV_DEN_BITS:0]   trial;
  logic [DIV_DEN_BITS:0]   diff;
  logic                    fits;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_NUM_BITS-1]};
    diff    = trial - {1'b0, den_r};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? diff[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];
    quo_nxt = {quo_r[DIV_NUM_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_BITS'(DIV_NUM_BITS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
endmodule

### rtl/gae_sqrt.sv
// iterative integer square root, one root bit per cycle
module gae_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [gae_pkg::SQ_IN_BITS-1:0]   val,
  output logic                             busy,
  output logic [gae_pkg::SQ_OUT_BITS-1:0]  root
);
  import gae_pkg::*;

  logic [SQ_IN_BITS-1:0]  val_r;
  logic [SQ_OUT_BITS+1:0] rem_r, rem_nxt;
  logic [SQ_OUT_BITS-1:0] root_r, root_nxt;
  logic [SQ_CNT_BITS-1:0] cnt_r;
  logic                   busy_r;
  logic [SQ_OUT_BITS+3:0] cur;
  logic [SQ_OUT_BITS+3:0] trial;
  logic [SQ_OUT_BITS+3:0] diff;
  logic                   fits;

  always_comb begin
    cur      = {rem_r, val_r[SQ_IN_BITS-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = cur - trial;
    fits     = cur >= trial;
    rem_nxt  = fits ? diff[SQ_OUT_BITS+1:0] : cur[SQ_OUT_BITS+1:0];
    root_nxt = {root_r[SQ_OUT_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= SQ_CNT_BITS'(SQ_OUT_BITS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[SQ_IN_BITS-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy = busy_r;
  assign root = root_r;
endmodule

### rtl/gae_dpath.sv
// datapath: body state, shared multiplier, root and divide units, result register
module gae_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  gae_pkg::in_item_t   in_data,
  input  gae_pkg::ctrl_cmd_t  cmd,
  output gae_pkg::ctrl_stat_t stat,
  input  logic                cfg_we,
  input  gae_pkg::cfg_addr_t  cfg_addr,
  input  logic [31:0]         cfg_wdata,
  output gae_pkg::out_item_t  out_data
);
  import gae_pkg::*;

  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, acc_x_r, acc_y_r;
  logic [31:0]        own_radius_r, grav_r;
  in_item_t           item_r;
  logic signed [32:0] dx_r, dy_r;
  logic [2*MUL_BITS-1:0] prod_r, d2_r;
  logic               ovl_r, coin_r;
  logic [30:0]        x_r, y_r, k_r, u_r;
  logic [1:0]         s_r;
  logic [63:0]        r2_r, gm_r;
  out_item_t          out_r;

  logic [32:0] ax, ay, amax, rs;
  logic [1:0]  s_nxt;
  logic [MUL_BITS-1:0] mul_a, mul_b;
  logic [DIV_NUM_BITS-1:0] div_num;
  logic [DIV_DEN_BITS-1:0] div_den;
  logic [DIV_NUM_BITS-1:0] div_quo;
  logic        div_busy, sqrt_busy;
  logic [SQ_OUT_BITS-1:0] root;

  always_comb begin
    ax    = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
    ay    = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
    amax  = (ax > ay) ? ax : ay;
    s_nxt = amax[32] ? 2'd2 : (amax[31] ? 2'd1 : 2'd0);
    rs    = {1'b0, own_radius_r} + {1'b0, item_r.other_radius};
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_AX:   begin mul_a = ax; mul_b = ax; end
      MUL_AY:   begin mul_a = ay; mul_b = ay; end
      MUL_RS:   begin mul_a = rs; mul_b = rs; end
      MUL_X:    begin mul_a = {2'b00, x_r}; mul_b = {2'b00, x_r}; end
      MUL_Y:    begin mul_a = {2'b00, y_r}; mul_b = {2'b00, y_r}; end
      MUL_GM:   begin mul_a = {1'b0, grav_r}; mul_b = {1'b0, item_r.other_mass}; end
      MUL_KU:   begin mul_a = {2'b00, k_r}; mul_b = {2'b00, u_r}; end
      MUL_ACCX: begin mul_a = {1'b0, abs32(acc_x_r)}; mul_b = {17'b0, item_r.dt_step}; end
      MUL_ACCY: begin mul_a = {1'b0, abs32(acc_y_r)}; mul_b = {17'b0, item_r.dt_step}; end
      MUL_VELX: begin mul_a = {1'b0, abs32(vel_x_r)}; mul_b = {17'b0, item_r.dt_step}; end
      MUL_VELY: begin mul_a = {1'b0, abs32(vel_y_r)}; mul_b = {17'b0, item_r.dt_step}; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_K: begin
        div_num = {gm_r, {FRAC_BITS{1'b0}}} >> {s_r, 1'b0};
        div_den = r2_r;
      end
      DIV_X: begin
        div_num = {19'b0, x_r, {UNIT_FRAC{1'b0}}};
        div_den = {32'b0, root};
      end
      DIV_Y: begin
        div_num = {19'b0, y_r, {UNIT_FRAC{1'b0}}};
        div_den = {32'b0, root};
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gae_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  gae_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .val   (r2_r),
    .busy  (sqrt_busy),
    .root  (root)
  );

  // body state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      vel_x_r      <= '0;
      vel_y_r      <= '0;
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      own_radius_r <= RADIUS_RESET;
      grav_r       <= GRAV_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_START_X:  pos_x_r      <= cfg_wdata;
          CFG_START_Y:  pos_y_r      <= cfg_wdata;
          CFG_START_VX: vel_x_r      <= cfg_wdata;
          CFG_START_VY: vel_y_r      <= cfg_wdata;
          CFG_RADIUS:   own_radius_r <= cfg_wdata;
          CFG_GRAV:     grav_r       <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.accx_upd) acc_x_r <= sat_add(acc_x_r, prod_r[UNIT_FRAC +: 32], dx_r[32]);
      if (cmd.accy_upd) acc_y_r <= sat_add(acc_y_r, prod_r[UNIT_FRAC +: 32], dy_r[32]);
      if (cmd.velx_upd) vel_x_r <= sat_add(vel_x_r, prod_r[DT_FRAC +: 32], acc_x_r[31]);
      if (cmd.vely_upd) vel_y_r <= sat_add(vel_y_r, prod_r[DT_FRAC +: 32], acc_y_r[31]);
      if (cmd.posx_upd) pos_x_r <= sat_add(pos_x_r, prod_r[DT_FRAC +: 32], vel_x_r[31]);
      if (cmd.posy_upd) pos_y_r <= sat_add(pos_y_r, prod_r[DT_FRAC +: 32], vel_y_r[31]);
      if (cmd.acc_clr) begin
        acc_x_r <= '0;
        acc_y_r <= '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.capture) begin
      item_r <= in_data;
      dx_r   <= {in_data.other_x[31], in_data.other_x} - {pos_x_r[31], pos_x_r};
      dy_r   <= {in_data.other_y[31], in_data.other_y} - {pos_y_r[31], pos_y_r};
      ovl_r  <= 1'b0;
      coin_r <= 1'b0;
    end
    if (cmd.d2_load) d2_r <= prod_r;
    if (cmd.d2_add)  d2_r <= d2_r + prod_r;
    if (cmd.ovl_load) begin
      ovl_r  <= d2_r <= prod_r;
      coin_r <= stat.coin;
      s_r    <= s_nxt;
      x_r    <= 31'(ax >> s_nxt);
      y_r    <= 31'(ay >> s_nxt);
    end
    if (cmd.r2_load) r2_r <= prod_r[63:0];
    if (cmd.r2_add)  r2_r <= r2_r + prod_r[63:0];
    if (cmd.gm_load) gm_r <= prod_r[63:0];
    if (cmd.k_load) begin
      k_r <= (div_quo[DIV_NUM_BITS-1:31] != '0) ? 31'h7FFF_FFFF : div_quo[30:0];
    end
    if (cmd.u_load) u_r <= div_quo[30:0];
    if (cmd.out_load) begin
      out_r.pos_x_out  <= pos_x_r;
      out_r.pos_y_out  <= pos_y_r;
      out_r.vel_x_out  <= vel_x_r;
      out_r.vel_y_out  <= vel_y_r;
      out_r.acc_x_out  <= acc_x_r;
      out_r.acc_y_out  <= acc_y_r;
      out_r.overlaps   <= ovl_r;
      out_r.coincident <= coin_r;
    end
  end

  always_comb begin
    stat.req_tick  = in_data.req_type == REQ_TICK;
    stat.coin      = (dx_r == '0) && (dy_r == '0);
    stat.div_busy  = div_busy;
    stat.sqrt_busy = sqrt_busy;
  end

  assign out_data = out_r;
endmodule

### rtl/gae_ctrl.sv
// controller: sequences one item through the datapath and runs the handshakes
module gae_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gae_pkg::ctrl_stat_t stat,
  output gae_pkg::ctrl_cmd_t  cmd
);
  import gae_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   units_idle;
  logic   out_free;

  assign units_idle = !stat.div_busy && !stat.sqrt_busy;
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = stat.req_tick ? ST_T_AX : ST_I_AX;
      ST_I_AX:    state_nxt = ST_I_AY;
      ST_I_AY:    state_nxt = ST_I_RS;
      ST_I_RS:    state_nxt = ST_I_OVL;
      ST_I_OVL:   state_nxt = stat.coin ? ST_DONE : ST_I_X;
      ST_I_X:     state_nxt = ST_I_Y;
      ST_I_Y:     state_nxt = ST_I_GM;
      ST_I_GM:    state_nxt = ST_I_SQRT;
      ST_I_SQRT:  state_nxt = ST_I_DIVK;
      ST_I_DIVK:  state_nxt = ST_I_WAITK;
      ST_I_WAITK: if (units_idle) state_nxt = ST_I_DIVX;
      ST_I_DIVX:  state_nxt = ST_I_WAITX;
      ST_I_WAITX: if (units_idle) state_nxt = ST_I_MULX;
      ST_I_MULX:  state_nxt = ST_I_ACCX;
      ST_I_ACCX:  state_nxt = ST_I_DIVY;
      ST_I_DIVY:  state_nxt = ST_I_WAITY;
      ST_I_WAITY: if (units_idle) state_nxt = ST_I_MULY;
      ST_I_MULY:  state_nxt = ST_I_ACCY;
      ST_I_ACCY:  state_nxt = ST_DONE;
      ST_T_AX:    state_nxt = ST_T_AY;
      ST_T_AY:    state_nxt = ST_T_VX;
      ST_T_VX:    state_nxt = ST_T_VY;
      ST_T_VY:    state_nxt = ST_T_PY;
      ST_T_PY:    state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_I_AX:    cmd.mul_sel = MUL_AX;
      ST_I_AY: begin
        cmd.d2_load = 1'b1;
        cmd.mul_sel = MUL_AY;
      end
      ST_I_RS: begin
        cmd.d2_add  = 1'b1;
        cmd.mul_sel = MUL_RS;
      end
      ST_I_OVL:   cmd.ovl_load = 1'b1;
      ST_I_X:     cmd.mul_sel = MUL_X;
      ST_I_Y: begin
        cmd.r2_load = 1'b1;
        cmd.mul_sel = MUL_Y;
      end
      ST_I_GM: begin
        cmd.r2_add  = 1'b1;
        cmd.mul_sel = MUL_GM;
      end
      ST_I_SQRT: begin
        cmd.gm_load    = 1'b1;
        cmd.sqrt_start = 1'b1;
      end
      ST_I_DIVK: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_K;
      end
      ST_I_WAITK: cmd.k_load = units_idle;
      ST_I_DIVX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_X;
      end
      ST_I_WAITX: cmd.u_load = units_idle;
      ST_I_MULX:  cmd.mul_sel = MUL_KU;
      ST_I_ACCX:  cmd.accx_upd = 1'b1;
      ST_I_DIVY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_Y;
      end
      ST_I_WAITY: cmd.u_load = units_idle;
      ST_I_MULY:  cmd.mul_sel = MUL_KU;
      ST_I_ACCY:  cmd.accy_upd = 1'b1;
      ST_T_AX:    cmd.mul_sel = MUL_ACCX;
      ST_T_AY: begin
        cmd.velx_upd = 1'b1;
        cmd.mul_sel  = MUL_ACCY;
      end
      ST_T_VX: begin
        cmd.vely_upd = 1'b1;
        cmd.mul_sel  = MUL_VELX;
      end
      ST_T_VY: begin
        cmd.posx_upd = 1'b1;
        cmd.mul_sel  = MUL_VELY;
      end
      ST_T_PY: begin
        cmd.posy_upd = 1'b1;
        cmd.acc_clr  = 1'b1;
      end
      ST_DONE:    cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
